/* rtl/rwvh_pkg.sv */
`default_nettype none
package rwvh_pkg;

   localparam int SINE_TABLE_DEPTH_DEF = 256;

   // register indexes
   localparam logic [2:0] CSR_AMPLITUDE      = 3'd0;
   localparam logic [2:0] CSR_INV_PERIOD     = 3'd1;
   localparam logic [2:0] CSR_INV_WAVELENGTH = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_X       = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_Z       = 3'd4;

   localparam logic signed [11:0] AMPLITUDE_RST      = 12'sd512;
   localparam logic        [15:0] INV_PERIOD_RST     = 16'd26214;
   localparam logic        [15:0] INV_WAVELENGTH_RST = 16'd4369;

   // square root: 34 bit radicand, 17 result bits, one bit per cell
   localparam int SQ_BITS  = 17;
   localparam int RAD_BITS = 34;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // q1.14 sine of a q30 angle in 0..pi/2, used at elaboration only
   // taylor terms through x^15, divisors are (2n)(2n+1)
   function automatic int sine_q14(longint unsigned a);
      longint unsigned a2;
      longint unsigned term;
      longint sum;
      longint unsigned r;
      a2 = (a * a) >> 30;
      term = a;
      sum = longint'(a);
      term = ((term * a2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * a2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * a2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * a2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * a2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      term = ((term * a2) >> 30) / 64'd156;
      sum = sum + longint'(term);
      term = ((term * a2) >> 30) / 64'd210;
      sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 32768) >> 16;
      if (r > 16384) r = 16384;
      return int'(r);
   endfunction

   // one square root cell state handed to the next cell
   typedef struct packed {
      logic                 vld;
      logic [RAD_BITS-1:0]  rem;
      logic [SQ_BITS-1:0]   root;
      logic [23:0]          t;
      logic [15:0]          x;
      logic [15:0]          z;
   } sq_word_type;

endpackage
`default_nettype wire

/* rtl/rwvh_sqrt_cell.sv */
`default_nettype none
module rwvh_sqrt_cell
   import rwvh_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  sq_word_type      d_in,
   output sq_word_type      d_out
);
   // restoring square root, result bit (SQ_BITS-1-STEP) decided here
   localparam int B = SQ_BITS - 1 - STEP;

   logic                    vld_ff;
   sq_word_type             pay_ff;
   sq_word_type             nxt;
   logic [RAD_BITS-1:0]     trial;

   always_comb begin
      nxt   = d_in;
      trial = RAD_BITS'(({1'b0, d_in.root} << (B + 1)) | (RAD_BITS'(1) << (2 * B)));
      if (d_in.rem >= trial) begin
         nxt.rem  = d_in.rem - trial;
         nxt.root = d_in.root | (SQ_BITS'(1) << B);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= d_in.vld;
      end
      if (en) begin
         pay_ff <= nxt;
      end
   end

   always_comb begin
      d_out     = pay_ff;
      d_out.vld = vld_ff;
   end
endmodule
`default_nettype wire

/* rtl/radial_wave_vertex_height_core.sv */
// a req word passes registers a, b, the 17 square root cells, c, d, e and o to become the rsp word
// throughput: one word per cycle while the rsp side does not stall; a 17 cell square root chain sets the depth
// the whole chain advances together and holds while the rsp side stalls
// reset: synchronous, clears the valid bits and loads the register defaults
`default_nettype none
module radial_wave_vertex_height_core
   import rwvh_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // vertex_x, vertex_z, time_now
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // height, out_x, out_z, 4'b0 pad
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int QN    = (SINE_TABLE_DEPTH / 4) > 0 ? (SINE_TABLE_DEPTH / 4) : 1;
   localparam int IW    = $clog2(4 * QN);
   localparam int MW    = $clog2(QN + 1);
   localparam int PW    = 24 + IW;

   logic signed [11:0] amp_ff;
   logic [15:0]        ip_ff, iw_ff;
   logic signed [15:0] ox_ff, oz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= AMPLITUDE_RST;
         ip_ff  <= INV_PERIOD_RST;
         iw_ff  <= INV_WAVELENGTH_RST;
         ox_ff  <= '0;
         oz_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AMPLITUDE:      amp_ff <= csr_wdata[11:0];
            CSR_INV_PERIOD:     ip_ff  <= csr_wdata;
            CSR_INV_WAVELENGTH: iw_ff  <= csr_wdata;
            CSR_ORIGIN_X:       ox_ff  <= csr_wdata;
            CSR_ORIGIN_Z:       oz_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advances unless the output word is stuck
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage a: world position
   logic               a_vld_ff;
   logic signed [16:0] a_wx_ff, a_wz_ff;
   logic [23:0]        a_t_ff;
   logic [15:0]        a_x_ff, a_z_ff;
   // stage b: squares
   logic               b_vld_ff;
   logic [33:0]        b_sx_ff, b_sz_ff;
   logic [23:0]        b_t_ff;
   logic [15:0]        b_x_ff, b_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         a_wx_ff <= 17'(signed'(req_tdata[15:0])) + 17'(ox_ff);
         a_wz_ff <= 17'(signed'(req_tdata[31:16])) + 17'(oz_ff);
         a_t_ff  <= req_tdata[55:32];
         a_x_ff  <= req_tdata[15:0];
         a_z_ff  <= req_tdata[31:16];
         b_sx_ff <= 34'(a_wx_ff) * 34'(a_wx_ff);
         b_sz_ff <= 34'(a_wz_ff) * 34'(a_wz_ff);
         b_t_ff  <= a_t_ff;
         b_x_ff  <= a_x_ff;
         b_z_ff  <= a_z_ff;
      end
   end

   sq_word_type chain [SQ_BITS+1];
   always_comb begin
      chain[0].vld  = b_vld_ff;
      chain[0].rem  = b_sx_ff + b_sz_ff;
      chain[0].root = '0;
      chain[0].t    = b_t_ff;
      chain[0].x    = b_x_ff;
      chain[0].z    = b_z_ff;
   end

   for (genvar g = 0; g < SQ_BITS; g++) begin : g_cell
      rwvh_sqrt_cell #(.STEP(g)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (chain[g]),
         .d_out (chain[g+1])
      );
   end

   sq_word_type sq;
   assign sq = chain[SQ_BITS];

   // stage c: phase products
   logic        c_vld_ff;
   logic [23:0] c_tp_ff, c_rw_ff;
   logic [15:0] c_x_ff, c_z_ff;
   // stage d: sine lookup
   logic               d_vld_ff;
   logic signed [15:0] d_s_ff;
   logic [15:0]        d_x_ff, d_z_ff;
   // stage e: product
   logic               e_vld_ff;
   logic signed [27:0] e_p_ff;
   logic [15:0]        e_x_ff, e_z_ff;

   logic [23:0]   phase;
   logic [PW-1:0] pstep;
   logic [IW-1:0] idx;
   logic [1:0]    quad;
   logic [MW-1:0] m, mi;
   logic [14:0]   tv;
   logic signed [15:0] s_val;

   // quarter-wave table, constant after elaboration
   logic [14:0] qtab [QN+1];
   for (genvar k = 0; k <= QN; k++) begin : g_qtab
      localparam longint unsigned ANG = (PI_Q30 * 64'(k)) / 64'(2 * QN);
      localparam logic [14:0] VAL = 15'(sine_q14(ANG));
      assign qtab[k] = VAL;
   end

   always_comb begin
      phase = c_tp_ff - c_rw_ff;
      pstep = PW'(phase) * PW'(4 * QN);
      idx   = pstep[PW-1 -: IW];
      // split the step count into quadrant and offset
      priority if (idx >= IW'(3 * QN)) begin
         quad = 2'd3;
         m    = MW'(idx - IW'(3 * QN));
      end else if (idx >= IW'(2 * QN)) begin
         quad = 2'd2;
         m    = MW'(idx - IW'(2 * QN));
      end else if (idx >= IW'(QN)) begin
         quad = 2'd1;
         m    = MW'(idx - IW'(QN));
      end else begin
         quad = 2'd0;
         m    = MW'(idx);
      end
      mi = MW'(QN) - m;
      unique case (quad)
         2'd0, 2'd2: tv = qtab[m];
         default:    tv = qtab[mi];
      endcase
      s_val = quad[1] ? -16'(signed'({1'b0, tv})) : 16'(signed'({1'b0, tv}));
   end

   logic signed [27:0] rnd;
   logic signed [13:0] hq;
   logic [11:0]        hsat;
   always_comb begin
      rnd = e_p_ff + 28'sd8192;
      hq  = rnd[27:14];
      if (hq > 14'sd2047) hsat = 12'h7ff;
      else if (hq < -14'sd2048) hsat = 12'h800;
      else hsat = hq[11:0];
   end

   logic        o_vld_ff;
   logic [47:0] o_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= sq.vld;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         o_vld_ff <= e_vld_ff;
      end
      if (en) begin
         c_tp_ff   <= 24'(sq.t * ip_ff);
         c_rw_ff   <= 24'(24'(sq.root) * 24'(iw_ff));
         c_x_ff    <= sq.x;
         c_z_ff    <= sq.z;
         d_s_ff    <= s_val;
         d_x_ff    <= c_x_ff;
         d_z_ff    <= c_z_ff;
         e_p_ff    <= 28'(amp_ff) * 28'(d_s_ff);
         e_x_ff    <= d_x_ff;
         e_z_ff    <= d_z_ff;
         o_data_ff <= {4'b0, e_z_ff, e_x_ff, hsat};
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = o_data_ff;
endmodule
`default_nettype wire

/* test/tb.sv */
module tb;
   import rwvh_pkg::*;

   localparam int QN = (SINE_TABLE_DEPTH_DEF / 4) > 0 ? (SINE_TABLE_DEPTH_DEF / 4) : 1;

   typedef struct packed {
      logic signed [11:0] height;
      logic [15:0]        x;
      logic [15:0]        z;
   } wave_out_type;

   class height_board;
      logic signed [11:0] amp;
      logic [15:0]        inv_per;
      logic [15:0]        inv_wl;
      logic signed [15:0] org_x;
      logic signed [15:0] org_z;
      int                 qsin[QN + 1];
      wave_out_type       pending[$];
      int                 errors;
      int                 checked;

      function new();
         longint unsigned a, a2, term, r;
         longint sum;
         amp = 512; inv_per = 26214; inv_wl = 4369; org_x = 0; org_z = 0;
         errors = 0; checked = 0;
         for (int k = 0; k <= QN; k++) begin
            a = (PI_Q30 * longint'(k)) / (2 * longint'(QN));
            a2 = (a * a) >> 30;
            term = a;
            sum = longint'(a);
            for (int n = 1; n <= 7; n++) begin
               term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) sum = sum - longint'(term);
               else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (longint'(sum) + 32768) >> 16;
            if (r > 16384) r = 16384;
            qsin[k] = int'(r);
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_AMPLITUDE:      amp = v[11:0];
            CSR_INV_PERIOD:     inv_per = v;
            CSR_INV_WAVELENGTH: inv_wl = v;
            CSR_ORIGIN_X:       org_x = v;
            CSR_ORIGIN_Z:       org_z = v;
            default: ;
         endcase
      endfunction

      function void note_vertex(logic [55:0] d);
         logic signed [15:0] vx, vz;
         longint wx, wz, rad, root, rbit, phase, idx, h;
         int quad, m, s;
         wave_out_type e;
         vx = d[15:0]; vz = d[31:16];
         wx = longint'(vx) + longint'(org_x);
         wz = longint'(vz) + longint'(org_z);
         rad = wx * wx + wz * wz;
         root = 0;
         rbit = 64'sd1 << 40;
         while (rbit > rad) rbit = rbit >> 2;
         while (rbit != 0) begin
            if (rad >= root + rbit) begin
               rad = rad - (root + rbit);
               root = (root >> 1) + rbit;
            end else root = root >> 1;
            rbit = rbit >> 2;
         end
         phase = (longint'(d[55:32]) * longint'(inv_per) - root * longint'(inv_wl))
                 & 64'hFFFFFF;
         idx = (phase * 4 * QN) >> 24;
         quad = int'((idx / QN) & 3);
         m = int'(idx % QN);
         case (quad)
            0: s = qsin[m];
            1: s = qsin[QN - m];
            2: s = -qsin[m];
            default: s = -qsin[QN - m];
         endcase
         h = (longint'(amp) * s + 8192) >>> 14;
         if (h > 2047) h = 2047;
         if (h < -2048) h = -2048;
         e.height = h[11:0]; e.x = vx; e.z = vz;
         pending.push_back(e);
      endfunction

      function void check_word(logic [47:0] d);
         wave_out_type got, e;
         got.height = d[11:0]; got.x = d[27:12]; got.z = d[43:28];
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected rsp word %h", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.height !== e.height) begin
            $display("%0t: height expected %0d actual %0d", $time, e.height, got.height);
            errors++;
         end
         if (got.x !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, got.x);
            errors++;
         end
         if (got.z !== e.z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.z, got.z);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   height_board board = new();
   int          sent = 0;
   int          stall_mode = 0;

   radial_wave_vertex_height_core uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      // receiver stall pattern: phases of full rate, light, heavy and random back-pressure
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= $urandom_range(0, 1);
      endcase
   end

   task automatic send_vertex(logic [15:0] vx, logic [15:0] vz, logic [23:0] t);
      req_tvalid <= 1'b1;
      req_tdata  <= {t, vz, vx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_vertex({t, vz, vx});
      sent++;
   endtask

   task automatic idle_cycles(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_reg(logic [2:0] idx, logic [15:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic random_burst(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && n > 0; i++, n--) begin
            case ($urandom_range(0, 3))
               0: send_vertex(16'($urandom_range(0, 255) - 128),
                              16'($urandom_range(0, 255) - 128), 24'($urandom));
               default: send_vertex(16'($urandom), 16'($urandom), 24'($urandom));
            endcase
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
      end
   endtask

   task automatic random_config();
      set_reg(CSR_AMPLITUDE, 16'($urandom));
      set_reg(CSR_INV_PERIOD, 16'($urandom));
      set_reg(CSR_INV_WAVELENGTH, 16'($urandom));
      set_reg(CSR_ORIGIN_X, 16'($urandom));
      set_reg(CSR_ORIGIN_Z, 16'($urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, passthrough and zero point at reset settings
      send_vertex(16'h0000, 16'h0000, 24'h000000);
      send_vertex(16'h7FFF, 16'h7FFF, 24'hFFFFFF);
      send_vertex(16'h8000, 16'h8000, 24'h000000);
      send_vertex(16'h8000, 16'h7FFF, 24'h800000);
      send_vertex(16'hFFFF, 16'h0001, 24'h000280);
      drain();
      // saturation with full negative amplitude, sweep phase through every quadrant
      set_reg(CSR_AMPLITUDE, 16'h0800);
      set_reg(CSR_INV_WAVELENGTH, 16'h0000);
      set_reg(CSR_INV_PERIOD, 16'hFFFF);
      for (int q = 0; q < 8; q++) send_vertex(16'h0100, 16'h0000, 24'(q * 32));
      send_vertex(16'h0000, 16'h0000, 24'h0000C0);
      drain();
      // zero period reciprocal, distance-only phase, extreme origins
      set_reg(CSR_AMPLITUDE, 16'h07FF);
      set_reg(CSR_INV_PERIOD, 16'h0000);
      set_reg(CSR_INV_WAVELENGTH, 16'hFFFF);
      set_reg(CSR_ORIGIN_X, 16'h7FFF);
      set_reg(CSR_ORIGIN_Z, 16'h8000);
      send_vertex(16'h7FFF, 16'h8000, 24'h123456);
      send_vertex(16'h8000, 16'h7FFF, 24'hFFFFFF);
      send_vertex(16'h0000, 16'h0000, 24'h000000);
      drain();
      set_reg(3'd7, 16'hFFFF);
      send_vertex(16'h1234, 16'hFEDC, 24'hABCDEF);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         stall_mode = ph % 4;
         if (ph == 0) begin
            set_reg(CSR_AMPLITUDE, 16'h0200);
            set_reg(CSR_INV_PERIOD, 16'd26214);
            set_reg(CSR_INV_WAVELENGTH, 16'd4369);
            set_reg(CSR_ORIGIN_X, 16'h0000);
            set_reg(CSR_ORIGIN_Z, 16'h0000);
         end else random_config();
         random_burst(140);
         drain();
      end
      stall_mode = 0;

      $display("covered %0d vertices, %0d responses, over 11 register settings",
               sent, board.checked);
      if (board.errors == 0)
         $display("** radial_wave_vertex_height_core: PASSED **");
      else
         $display("** radial_wave_vertex_height_core: FAILED **");
      $finish;
   end

   initial begin
      #3000000;
      $display("** radial_wave_vertex_height_core: FAILED **");
      $finish;
   end

endmodule
